@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: seven-segment text encoder shared definitions
// Payload types, character codes, segment constants and the font tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

	// Bit 7 is the decimal point, bits 6..0 are segments g..a
	localparam logic [7:0] SEG_BLANK  = 8'h00;
	localparam logic [7:0] SEG_MINUS  = 8'h40;
	localparam logic [7:0] SEG_LOWBAR = 8'h08;
	localparam logic [7:0] SEG_ERROR  = 8'h49;
	localparam logic [7:0] SEG_POINT  = 8'h80;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_POINT   = 8'h2e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWBAR  = 8'h5f;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_SHIFT = 8'h20;

	localparam int unsigned NUM_DIGITS = 4;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} tss_in_t;

	typedef struct packed {
		logic [7:0] digit0_segments;
		logic [7:0] digit1_segments;
		logic [7:0] digit2_segments;
		logic [7:0] digit3_segments;
	} tss_out_t;

	// Classification of one character, handed from the glyph lookup to the frame logic
	typedef struct packed {
		logic       nul;
		logic       point;
		logic [7:0] pattern;
	} tss_glyph_t;

	function automatic logic [7:0] numeral_glyph(input logic [3:0] idx);
		logic [7:0] pat;
		case (idx)
			4'd0: pat = 8'h3f;
			4'd1: pat = 8'h06;
			4'd2: pat = 8'h5b;
			4'd3: pat = 8'h4f;
			4'd4: pat = 8'h66;
			4'd5: pat = 8'h6d;
			4'd6: pat = 8'h7d;
			4'd7: pat = 8'h07;
			4'd8: pat = 8'h7f;
			4'd9: pat = 8'h6f;
			default: pat = SEG_ERROR;
		endcase
		return pat;
	endfunction

	function automatic logic [7:0] letter_glyph(input logic [4:0] idx);
		logic [7:0] pat;
		case (idx)
			5'd0:  pat = 8'h77;
			5'd1:  pat = 8'h7c;
			5'd2:  pat = 8'h58;
			5'd3:  pat = 8'h5e;
			5'd4:  pat = 8'h79;
			5'd5:  pat = 8'h71;
			5'd6:  pat = 8'h6f;
			5'd7:  pat = 8'h74;
			5'd8:  pat = 8'h30;
			5'd9:  pat = 8'h0e;
			5'd11: pat = 8'h38;
			5'd13: pat = 8'h54;
			5'd14: pat = 8'h5c;
			5'd15: pat = 8'h73;
			5'd16: pat = 8'h67;
			5'd17: pat = 8'h50;
			5'd18: pat = 8'h6d;
			5'd19: pat = 8'h78;
			5'd20: pat = 8'h1c;
			5'd24: pat = 8'h6e;
			default: pat = SEG_ERROR;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tss_stream_if.sv @@
// ----------------------------------------------------------------------------
// tss_stream_if: valid/ready stream channel
// One transaction moves per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/tss_glyph.sv @@
// ----------------------------------------------------------------------------
// tss_glyph: character to segment pattern lookup
// Case-folds one byte and maps it through the font tables.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_glyph
	import tss_pkg::*;
(
	input  wire logic [7:0] char_code,
	output tss_glyph_t      glyph
);
	logic [7:0] folded;
	logic [7:0] num_off;
	logic [7:0] let_off;

	always_comb begin
		folded = char_code;
		if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
			folded = char_code + CASE_SHIFT;
		end
		num_off = folded - CH_ZERO;
		let_off = folded - CH_LOWER_A;

		glyph.nul   = (folded == CH_NUL);
		glyph.point = (folded == CH_POINT);
		if (folded >= CH_ZERO && folded <= CH_NINE) begin
			glyph.pattern = numeral_glyph(num_off[3:0]);
		end else if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) begin
			glyph.pattern = letter_glyph(let_off[4:0]);
		end else if (folded == CH_SPACE || (folded >= CH_TAB && folded <= CH_CR)) begin
			glyph.pattern = SEG_BLANK;
		end else if (folded == CH_MINUS) begin
			glyph.pattern = SEG_MINUS;
		end else if (folded == CH_LOWBAR) begin
			glyph.pattern = SEG_LOWBAR;
		end else if (folded == CH_POINT) begin
			glyph.pattern = SEG_POINT;
		end else begin
			glyph.pattern = SEG_ERROR;
		end
	end
endmodule

`default_nettype wire

@@ rtl/text_to_seven_segment_encoder_top.sv @@
// ----------------------------------------------------------------------------
// text_to_seven_segment_encoder_top: text frame to four-digit segment patterns
// Packs a stream of ASCII characters into four seven-segment digit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per transaction (char_code, last_char). The
//   block takes one transaction every cycle unless stalled (see Stall). Each
//   character goes through a font lookup and updates the four-digit frame;
//   a '.' may merge into the previous digit as its decimal point.
//   out_ch carries one transaction per frame, on the character marked last:
//   the four patterns, digit0 leftmost, bit 7 the decimal point.
//   Path: a character is registered in the input stage; its frame result is
//   then registered in the result register that drives out_ch.
//   Throughput: one character per cycle while in_ch.ready is high; the font
//   lookup and slot update between the input stage and the frame registers
//   are combinational.
//   Stall: while out_ch is held with a result pending, ordinary characters
//   still flow; a second last character waits in the input stage, and
//   in_ch.ready drops only then.
//   Reset: arst_n clears the frame to blank digits, both stages to empty.
//   Only the first MAX_CHARS characters of a frame count; a NUL or four
//   filled digits drop the rest until the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_seven_segment_encoder_top
	import tss_pkg::*;
#(
	parameter int unsigned MAX_CHARS = 7
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tss_stream_if.sink   in_ch,
	tss_stream_if.source out_ch
);
	localparam int unsigned CW = $clog2(MAX_CHARS + 1);

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       s1_adv;

	// Frame state
	logic [7:0]    store_q [NUM_DIGITS];
	logic [2:0]    slot_q;
	logic [CW-1:0] chars_q;
	logic          ignore_q;

	// Result register
	logic     out_valid_q;
	tss_out_t out_q;

	tss_glyph_t glyph;

	logic [7:0]    store_nxt [NUM_DIGITS];
	logic [2:0]    slot_nxt;
	logic [CW-1:0] chars_nxt;
	logic          ignore_nxt;
	logic          take;
	logic [1:0]    prev_idx;

	// Advance the input stage unless a frame result would overwrite an untaken one
	assign s1_adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			char_s1 <= in_ch.payload.char_code;
			last_s1 <= in_ch.payload.last_char;
		end
	end

	tss_glyph u_glyph (
		.char_code (char_s1),
		.glyph     (glyph)
	);

	// Slot update for the character in the input stage
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			store_nxt[i] = store_q[i];
		end
		slot_nxt   = slot_q;
		chars_nxt  = chars_q;
		ignore_nxt = ignore_q;
		prev_idx   = slot_q[1:0] - 2'd1;
		take       = !ignore_q && (slot_q < 3'(NUM_DIGITS)) && (chars_q < CW'(MAX_CHARS));

		if (take) begin
			chars_nxt = chars_q + CW'(1);
			if (glyph.nul) begin
				ignore_nxt = 1'b1;
			end else if (glyph.point && slot_q != 3'd0 && !store_q[prev_idx][7]) begin
				// merge the point into the previous digit
				store_nxt[prev_idx] = store_q[prev_idx] | SEG_POINT;
			end else begin
				store_nxt[slot_q[1:0]] = glyph.pattern;
				slot_nxt               = slot_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				store_q[i] <= SEG_BLANK;
			end
			slot_q   <= '0;
			chars_q  <= '0;
			ignore_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				// restart the frame blank after the last character
				for (int i = 0; i < NUM_DIGITS; i++) begin
					store_q[i] <= SEG_BLANK;
				end
				slot_q   <= '0;
				chars_q  <= '0;
				ignore_q <= 1'b0;
			end else begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					store_q[i] <= store_nxt[i];
				end
				slot_q   <= slot_nxt;
				chars_q  <= chars_nxt;
				ignore_q <= ignore_nxt;
			end
		end
	end

	// Result register: load on the last character, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			out_q.digit0_segments <= store_nxt[0];
			out_q.digit1_segments <= store_nxt[1];
			out_q.digit2_segments <= store_nxt[2];
			out_q.digit3_segments <= store_nxt[3];
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= 3'(NUM_DIGITS))
		else $error("slot count beyond digit count");

	a_chars_range: assert property (@(posedge clk) disable iff (!arst_n)
		chars_q <= CW'(MAX_CHARS))
		else $error("character count beyond limit");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> out_valid_q)
		else $error("last character did not produce a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/tss_frame_checker.sv @@
// ----------------------------------------------------------------------------
// tss_frame_checker: frame predictor and result comparator
// Watches both channels of the seven-segment text encoder, builds the
// expected four-digit frame from each accepted character and compares every
// emitted frame against the oldest expectation.
// ----------------------------------------------------------------------------

module tss_frame_checker
	import tss_pkg::*;
#(
	parameter int unsigned MAX_CHARS = 7
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready,
	input  tss_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  tss_out_t out_data,
	output int       frames_pending,
	output int       fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Font images, entry 0 in the low byte
	localparam logic [10*8-1:0] NUMERAL_FONT = {
		8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
	};
	localparam logic [26*8-1:0] LETTER_FONT = {
		8'h49, 8'h6e, 8'h49, 8'h49, 8'h49, 8'h1c, 8'h78, 8'h6d, 8'h50, 8'h67,
		8'h73, 8'h5c, 8'h54, 8'h49, 8'h38, 8'h49, 8'h0e, 8'h30, 8'h74, 8'h6f,
		8'h71, 8'h79, 8'h5e, 8'h58, 8'h7c, 8'h77
	};

	logic [7:0] frame_digits [NUM_DIGITS];
	int unsigned digits_filled;
	int unsigned chars_taken;
	logic        frame_muted;
	tss_out_t    expected_frames [$];
	tss_out_t    want;

	function automatic logic [7:0] glyph_for(input logic [7:0] code);
		logic [7:0] folded;
		logic [7:0] idx;
		folded = code;
		if (code >= CH_UPPER_A && code <= CH_UPPER_Z)
			folded = code + CASE_SHIFT;
		if (folded >= CH_ZERO && folded <= CH_NINE) begin
			idx = folded - CH_ZERO;
			return NUMERAL_FONT[idx*8 +: 8];
		end
		if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) begin
			idx = folded - CH_LOWER_A;
			return LETTER_FONT[idx*8 +: 8];
		end
		if (folded == CH_SPACE || (folded >= CH_TAB && folded <= CH_CR))
			return SEG_BLANK;
		if (folded == CH_MINUS)
			return SEG_MINUS;
		if (folded == CH_LOWBAR)
			return SEG_LOWBAR;
		return SEG_ERROR;
	endfunction

	task automatic place_digit(input logic [7:0] pat);
		if (digits_filled < NUM_DIGITS) begin
			frame_digits[digits_filled] = pat;
			digits_filled++;
		end
	endtask

	task automatic clear_frame();
		for (int k = 0; k < NUM_DIGITS; k++)
			frame_digits[k] = SEG_BLANK;
		digits_filled = 0;
		chars_taken   = 0;
		frame_muted   = 1'b0;
	endtask

	task automatic absorb_char(input logic [7:0] code);
		if (frame_muted || digits_filled >= NUM_DIGITS || chars_taken >= MAX_CHARS)
			return;
		chars_taken++;
		if (code == CH_NUL) begin
			frame_muted = 1'b1;
		end else if (code == CH_POINT) begin
			// merge into the previous digit unless it already shows its point
			if (digits_filled != 0 && !frame_digits[digits_filled-1][7])
				frame_digits[digits_filled-1][7] = 1'b1;
			else
				place_digit(SEG_POINT);
		end else begin
			place_digit(glyph_for(code));
		end
	endtask

	task automatic report_mismatch(input string what, input tss_out_t exp_frame);
		fail_count++;
		if (fail_count <= 10)
			$display("%t: %s: expected %02h %02h %02h %02h, got %02h %02h %02h %02h",
				$realtime, what,
				exp_frame.digit0_segments, exp_frame.digit1_segments,
				exp_frame.digit2_segments, exp_frame.digit3_segments,
				out_data.digit0_segments, out_data.digit1_segments,
				out_data.digit2_segments, out_data.digit3_segments);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			expected_frames.delete();
			frames_pending = 0;
			fail_count     = 0;
		end else begin
			// compare first, so a result never meets an expectation queued this edge
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("frame with none expected", '0);
				end else begin
					want = expected_frames.pop_front();
					if (out_data.digit0_segments !== want.digit0_segments ||
					    out_data.digit1_segments !== want.digit1_segments ||
					    out_data.digit2_segments !== want.digit2_segments ||
					    out_data.digit3_segments !== want.digit3_segments)
						report_mismatch("frame mismatch", want);
				end
			end
			if (in_valid && in_ready) begin
				absorb_char(in_data.char_code);
				if (in_data.last_char) begin
					expected_frames.push_back({frame_digits[0], frame_digits[1],
						frame_digits[2], frame_digits[3]});
					clear_frame();
				end
			end
			frames_pending = expected_frames.size();
		end
	end

endmodule

@@ bench/tb_text_to_seven_segment_encoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_text_to_seven_segment_encoder_top: testbench for the text encoder
// Sends directed and random text frames through the encoder under several
// idle and stall mixes, with a frame checker comparing every result.
// ----------------------------------------------------------------------------

module tb_text_to_seven_segment_encoder_top;
	import tss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_CHARS     = 7;
	localparam int unsigned PHASE_ITEMS   = 500;
	localparam int unsigned LONG_HOLD     = 60;
	localparam int unsigned HOLD_AT_ITEM  = 200;
	localparam int unsigned SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Idle and stall odds in percent, set per phase by the stimulus
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	// Long hold-off requests, served one at a time by the receiver
	int unsigned hold_requests  = 0;

	int frames_pending;
	int fail_count;

	tss_stream_if #(.payload_t(tss_in_t))  in_ch  ();
	tss_stream_if #(.payload_t(tss_out_t)) out_ch ();

	text_to_seven_segment_encoder_top #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	tss_frame_checker #(
		.MAX_CHARS(MAX_CHARS)
	) frame_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_data        (in_ch.payload),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_data       (out_ch.payload),
		.frames_pending (frames_pending),
		.fail_count     (fail_count)
	);

	always #6 clk = ~clk;

	// Hard stop in case the handshake locks up
	initial begin
		#5ms;
		$display("text_to_seven_segment_encoder_top verification failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	// The hold-off is counted here so the sender keeps offering characters
	// meanwhile and the encoder backs up into its input stage.
	initial begin
		int unsigned hold_left;
		int unsigned holds_served;
		hold_left    = 0;
		holds_served = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one character; called and returning at a falling edge.
	// Valid stays high on return so back-to-back transactions need no gap.
	task automatic send_char(input logic [7:0] code, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= '{char_code: code, last_char: last};
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid and hold off the sender until every expected frame has come out
	task automatic drain_frames();
		in_ch.valid <= 1'b0;
		while (frames_pending != 0)
			@(negedge clk);
	endtask

	// Mostly printable text, with whitespace, bars, points, NULs and raw bytes
	function automatic logic [7:0] pick_char();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 20) return CH_ZERO + 8'($urandom_range(9));
		if (roll < 35) return CH_UPPER_A + 8'($urandom_range(25));
		if (roll < 50) return CH_LOWER_A + 8'($urandom_range(25));
		if (roll < 54) return CH_SPACE;
		if (roll < 58) return CH_TAB + 8'($urandom_range(4));
		if (roll < 63) return CH_MINUS;
		if (roll < 68) return CH_LOWBAR;
		if (roll < 84) return CH_POINT;
		if (roll < 87) return CH_NUL;
		if (roll < 93) return 8'h80 | 8'($urandom_range(127));
		return 8'($urandom_range(255));
	endfunction

	// Send one frame of random text, last flag on its final character.
	// Most frames are short enough to stay under the character limit; a few
	// run long, and some are pure random bytes.
	task automatic send_random_frame(inout int unsigned sent);
		int unsigned len;
		int unsigned roll;
		bit          raw;
		roll = $urandom_range(99);
		if (roll < 85)
			len = $urandom_range(9, 1);
		else if (roll < 97)
			len = $urandom_range(20, 10);
		else
			len = $urandom_range(70, 21);
		raw = ($urandom_range(9) == 0);
		for (int unsigned k = 0; k < len; k++) begin
			send_char(raw ? 8'($urandom_range(255)) : pick_char(), k == len - 1);
			sent++;
			// trigger the long receiver hold-off once, mid-phase
			if (sent == HOLD_AT_ITEM && hold_requests == 0)
				hold_requests++;
		end
	endtask

	initial begin
		int unsigned phase_sent;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames, no idling.
		// Lone point at the start of a frame
		send_char(CH_POINT, 1'b1);
		// Point merges into the digit, then two points take digits of their own
		send_char("8", 1'b0);
		send_char(CH_POINT, 1'b0);
		send_char(CH_POINT, 1'b0);
		send_char(CH_POINT, 1'b1);
		// Case folding and font extremes; a point after four digits is dropped
		send_char(CH_UPPER_A, 1'b0);
		send_char(CH_LOWER_Z, 1'b0);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_NINE, 1'b0);
		send_char(CH_POINT, 1'b1);
		// Bars and whitespace
		send_char(CH_MINUS, 1'b0);
		send_char(CH_LOWBAR, 1'b0);
		send_char(CH_TAB, 1'b0);
		send_char(CH_CR, 1'b1);
		// NUL mutes the rest of the frame, last character included
		send_char("1", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char("2", 1'b1);
		// Bytes outside ASCII and the DEL control code give the error glyph
		send_char(8'hff, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h7f, 1'b0);
		send_char(CH_SPACE, 1'b1);
		// Character limit reached with the display full
		send_char("1", 1'b0);
		send_char(CH_POINT, 1'b0);
		send_char("h", 1'b0);
		send_char(CH_POINT, 1'b0);
		send_char("E", 1'b0);
		send_char(CH_POINT, 1'b0);
		send_char("5", 1'b0);
		send_char(CH_POINT, 1'b1);
		drain_frames();

		// Random phases: free run, idle sender, stalling receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS)
				send_random_frame(phase_sent);
			// pause the sender until the encoder has emptied out
			drain_frames();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && frames_pending == 0) begin
			$display("text_to_seven_segment_encoder_top verification clean");
		end else begin
			$display("text_to_seven_segment_encoder_top verification failed");
		end
		$finish;
	end

endmodule
